>>> src/upi_pkg.sv
// Package for the unicycle pose integrator: widths, CORDIC atan table and
// shared constants. No dependencies.
package upi_pkg;

	localparam int AtanLen = 24;
	localparam logic signed [33:0] CordicGain = 34'sd652032874;
	localparam logic [30:0] InvPiQ32 = 31'd1367130551;

	localparam logic [2:0] RegMaxSpeed = 3'd0;
	localparam logic [2:0] RegMaxTurn  = 3'd1;
	localparam logic [2:0] RegTimeStep = 3'd2;
	localparam logic [2:0] RegStartX   = 3'd3;
	localparam logic [2:0] RegStartY   = 3'd4;
	localparam logic [2:0] RegStartHd  = 3'd5;

	function automatic logic [29:0] atan_entry(input logic [4:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0: r = 30'd536870912;
			5'd1: r = 30'd316933406;
			5'd2: r = 30'd167458907;
			5'd3: r = 30'd85004756;
			5'd4: r = 30'd42667331;
			5'd5: r = 30'd21354465;
			5'd6: r = 30'd10679838;
			5'd7: r = 30'd5340245;
			5'd8: r = 30'd2670163;
			5'd9: r = 30'd1335087;
			5'd10: r = 30'd667544;
			5'd11: r = 30'd333772;
			5'd12: r = 30'd166886;
			5'd13: r = 30'd83443;
			5'd14: r = 30'd41722;
			5'd15: r = 30'd20861;
			5'd16: r = 30'd10430;
			5'd17: r = 30'd5215;
			5'd18: r = 30'd2608;
			5'd19: r = 30'd1304;
			5'd20: r = 30'd652;
			5'd21: r = 30'd326;
			5'd22: r = 30'd163;
			5'd23: r = 30'd81;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

>>> src/upi_cordic.sv
// Iterative CORDIC sine/cosine, one rotation per cycle.
// Depends on upi_pkg for the atan table and gain.
module upi_cordic #(
	parameter int Steps = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [15:0]         angle,
	output logic                done,
	output logic signed [33:0]  cos_out,
	output logic signed [33:0]  sin_out
);
	localparam int N = (Steps < upi_pkg::AtanLen) ? Steps : upi_pkg::AtanLen;

	logic signed [33:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic [4:0] i_q;
	logic busy_q, flip_q;
	logic [31:0] z32;
	logic signed [33:0] xs, ys;
	logic signed [32:0] at;

	assign z32 = {angle, 16'd0};
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = {3'd0, upi_pkg::atan_entry(i_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				if (i_q == 5'(N - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				i_q <= i_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			flip_q <= z32[31] ^ z32[30];
			x_q <= upi_pkg::CordicGain;
			y_q <= '0;
			z_q <= $signed({z32[31] ^ (z32[31] ^ z32[30]), z32[31] ^ (z32[31] ^ z32[30]),
				z32[30:0]});
		end else if (busy_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign cos_out = flip_q ? -x_q : x_q;
	assign sin_out = flip_q ? -y_q : y_q;
endmodule

>>> src/upi_serial_mul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, shift and add.
// Self-contained; no package use.
module upi_serial_mul #(
	parameter int AW = 34,
	parameter int BW = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	output logic                     done,
	output logic signed [AW+BW-1:0]  prod
);
	localparam int CW = $clog2(BW + 1);
	logic signed [AW+BW-1:0] acc_q, a_q;
	logic [BW-1:0] b_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(BW - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q <= (AW+BW)'(a);
			b_q <= b;
		end else if (busy_q) begin
			// Top bit of a two's complement multiplier has negative weight.
			if (b_q[0])
				acc_q <= (cnt_q == CW'(BW - 1)) ? acc_q - a_q : acc_q + a_q;
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign prod = acc_q;
endmodule

>>> src/unicycle_pose_integrator_core.sv
// Top level of the unicycle pose integrator: register file, sequencer,
// CORDIC and a shared bit-serial multiplier. Depends on upi_pkg, upi_cordic
// and upi_serial_mul.
//
// Usage: write the six configuration registers through cfg_we/cfg_index/
// cfg_data while idle. Each s_tdata transaction is one tick; tuser carries
// func (1 loads the start pose, 0 integrates). Each tick yields exactly one
// m_tdata transaction with the new pose, world velocity and turn rate.
// s_tdata packs cmd_speed, cmd_turn, noise_speed, noise_turn from bit 0.
// m_tdata packs pos_x, pos_y, heading, vel_x, vel_y, turn_rate from bit 0.
// Sequence: a load tick outputs the start pose with zero velocity and turn
// rate, valid in the cycle after acceptance. An integrate tick runs the
// CORDIC (min(CORDIC_STEPS,24) rotations) and then six serial multiplies on
// the shared multiplier, one after another (v*cos, v*sin, vx*dt, vy*dt, w*dt,
// then that product times 2^32/pi); most of its time goes to the multiplies.
// The next tick is accepted once the result has been taken. One tick is
// worked at a time. While the receiver stalls the block holds its output
// register and accepts no new tick. Reset clears the pose and loads register
// reset values.
module unicycle_pose_integrator_core #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,  // cmd_speed, cmd_turn, noise_speed, noise_turn
	input  logic         s_tuser,  // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata   // pos_x, pos_y, heading, vel_x, vel_y, turn_rate
);
	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_COR  = 9'b000000010,
		ST_MVX  = 9'b000000100,
		ST_MVY  = 9'b000001000,
		ST_MPX  = 9'b000010000,
		ST_MPY  = 9'b000100000,
		ST_MW1  = 9'b001000000,
		ST_MW2  = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [14:0] max_speed_q, max_turn_q;
	logic [15:0] time_step_q, start_hd_q, hd_q;
	logic [31:0] start_x_q, start_y_q, x_q, y_q;
	logic signed [15:0] v_q, w_q, vx_q, vy_q;
	logic [127:0] out_q;

	// Clamp and add noise.
	function automatic logic signed [15:0] lim_add(input logic signed [15:0] c,
			input logic [14:0] l, input logic signed [15:0] n);
		logic signed [17:0] cl, s;
		cl = 18'(c);
		if (cl > $signed({3'd0, l})) cl = $signed({3'd0, l});
		if (cl < -$signed({3'd0, l})) cl = -$signed({3'd0, l});
		s = cl + 18'(n);
		if (s > 18'sd32767) s = 18'sd32767;
		if (s < -18'sd32768) s = -18'sd32768;
		return s[15:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [65:0] p);
		logic signed [35:0] r;
		r = 36'((p + 66'sd536870912) >>> 30);
		if (r > 36'sd32767) return 16'sh7fff;
		if (r < -36'sd32768) return 16'sh8000;
		return r[15:0];
	endfunction

	function automatic logic [31:0] pos_add(input logic [31:0] p,
			input logic signed [65:0] m);
		logic signed [33:0] s;
		s = 34'($signed(p)) + 34'((m + 66'sd2048) >>> 12);
		if (s > 34'sd2147483647) return 32'h7fffffff;
		if (s < -34'sd2147483648) return 32'h80000000;
		return s[31:0];
	endfunction

	logic cor_start, cor_done;
	logic signed [33:0] cos_v, sin_v;
	logic mul_start, mul_done;
	logic signed [33:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [65:0] prod;
	logic [15:0] hd_next;

	upi_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
		.clk, .arst_n, .start(cor_start), .angle(hd_q),
		.done(cor_done), .cos_out(cos_v), .sin_out(sin_v));

	upi_serial_mul #(.AW(34), .BW(32)) u_mul (
		.clk, .arst_n, .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(prod));

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata = out_q;

	// Heading step: rounded product shifted down to the 16-bit binary angle.
	assign hd_next = hd_q + 16'((prod + 66'sd17592186044416) >>> 45);

	logic s_acc;
	assign s_acc = s_tvalid && s_tready;
	assign cor_start = s_acc && !s_tuser;

	always_comb begin
		mul_a = 34'(v_q);
		mul_b = 32'(cos_v);
		mul_start = 1'b0;
		unique case (state_q)
			ST_COR: begin mul_start = cor_done; mul_a = cos_v; mul_b = 32'(v_q); end
			ST_MVX: begin mul_start = mul_done; mul_a = sin_v; mul_b = 32'(v_q); end
			ST_MVY: begin mul_start = mul_done; mul_a = 34'({1'b0, time_step_q});
				mul_b = 32'(vx_q); end
			ST_MPX: begin mul_start = mul_done; mul_a = 34'({1'b0, time_step_q});
				mul_b = 32'(vy_q); end
			ST_MPY: begin mul_start = mul_done; mul_a = 34'({1'b0, time_step_q});
				mul_b = 32'(w_q); end
			ST_MW1: begin mul_start = mul_done; mul_a = 34'({1'b0, upi_pkg::InvPiQ32});
				mul_b = 32'(prod); end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			max_speed_q <= 15'd6144;
			max_turn_q <= 15'd9830;
			time_step_q <= 16'd655;
			start_x_q <= '0;
			start_y_q <= '0;
			start_hd_q <= '0;
			x_q <= '0;
			y_q <= '0;
			hd_q <= '0;
			v_q <= '0;
			w_q <= '0;
			vx_q <= '0;
			vy_q <= '0;
			out_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					upi_pkg::RegMaxSpeed: max_speed_q <= cfg_data[14:0];
					upi_pkg::RegMaxTurn:  max_turn_q <= cfg_data[14:0];
					upi_pkg::RegTimeStep: time_step_q <= cfg_data[15:0];
					upi_pkg::RegStartX:   start_x_q <= cfg_data;
					upi_pkg::RegStartY:   start_y_q <= cfg_data;
					upi_pkg::RegStartHd:  start_hd_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: if (s_acc) begin
					if (s_tuser) begin
						x_q <= start_x_q;
						y_q <= start_y_q;
						hd_q <= start_hd_q;
						out_q <= {48'd0, start_hd_q, start_y_q, start_x_q};
						state_q <= ST_OUT;
					end else begin
						v_q <= lim_add(s_tdata[15:0], max_speed_q, s_tdata[47:32]);
						w_q <= lim_add(s_tdata[31:16], max_turn_q, s_tdata[63:48]);
						state_q <= ST_COR;
					end
				end
				ST_COR: if (cor_done) state_q <= ST_MVX;
				ST_MVX: if (mul_done) begin vx_q <= sat16(prod); state_q <= ST_MVY; end
				ST_MVY: if (mul_done) begin vy_q <= sat16(prod); state_q <= ST_MPX; end
				ST_MPX: if (mul_done) begin x_q <= pos_add(x_q, prod); state_q <= ST_MPY; end
				ST_MPY: if (mul_done) begin y_q <= pos_add(y_q, prod); state_q <= ST_MW1; end
				ST_MW1: if (mul_done) state_q <= ST_MW2;
				ST_MW2: if (mul_done) begin
					hd_q <= hd_next;
					out_q <= {w_q, vy_q, vx_q, hd_next, y_q, x_q};
					state_q <= ST_OUT;
				end
				ST_OUT: if (m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
